// ===== src/afsg_pkg.sv =====
// ----------------------------------------------------------------------------
// AFSG package
// Shared widths, codes and types of the face stencil entry generator.
// ----------------------------------------------------------------------------
package afsg_pkg;

  localparam int IDX_W     = 34;  // matrix row and column indexes
  localparam int SIZE_W    = 7;   // cells per patch along one axis
  localparam int AREA_W    = 2 * SIZE_W;
  localparam int CELL_W    = 3 * SIZE_W;
  localparam int PIDX_W    = 16;
  localparam int COORD_W   = 6;
  localparam int COEF_W    = 4;
  localparam int KIND_W    = 3;
  localparam int SIDE_W    = 3;
  localparam int DELTA_W   = 16;  // signed column step between partner cells
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // Face codes; only the highest legal one is needed by name
  localparam logic [SIDE_W-1:0] SIDE_TOP = 3'd5;

  // Axis normal to the face, taken from the upper bits of the face code
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Neighbour kinds
  localparam logic [KIND_W-1:0] KIND_DIRICHLET = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEUMANN   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SAME      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COARSE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FINE      = 3'd4;

  // Coefficients in units of 1/(6 h^2)
  localparam logic signed [COEF_W-1:0] COEF_DIRICHLET   = -4'sd6;
  localparam logic signed [COEF_W-1:0] COEF_NEUMANN     = 4'sd6;
  localparam logic signed [COEF_W-1:0] COEF_SAME        = 4'sd6;
  localparam logic signed [COEF_W-1:0] COEF_CRS_SELF    = 4'sd5;
  localparam logic signed [COEF_W-1:0] COEF_CRS_PARTNER = -4'sd1;
  localparam logic signed [COEF_W-1:0] COEF_CRS_CELL    = 4'sd4;
  localparam logic signed [COEF_W-1:0] COEF_FINE_SELF   = -4'sd2;
  localparam logic signed [COEF_W-1:0] COEF_FINE_CELL   = 4'sd2;

  typedef struct packed {
    logic [SIZE_W-1:0] x;
    logic [SIZE_W-1:0] y;
    logic [SIZE_W-1:0] z;
  } afsg_size_t;

  // Stage advance strobes shared by the address pipeline and the remainder unit
  typedef struct packed {
    logic b;
    logic c;
    logic d;
  } afsg_pipe_en_t;

  // One face cell, reduced to what the entry sequencer needs
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   bcol;   // neighbour base column
    logic [DELTA_W-1:0] dsx;    // signed step to the x partner
    logic [DELTA_W-1:0] dsy;    // signed step to the y partner
    logic [DELTA_W-1:0] dxy;    // dsx + dsy
  } afsg_item_t;

endpackage

// ===== src/afsg_rem_pipe.sv =====
// ----------------------------------------------------------------------------
// AFSG remainder pipeline
// Two-lane restoring remainder, two quotient bits per stage over three stages.
// ----------------------------------------------------------------------------
module afsg_rem_pipe import afsg_pkg::*; (
  input  logic                clk,
  input  afsg_pipe_en_t       en,
  input  logic [COORD_W-1:0]  num_x,
  input  logic [COORD_W-1:0]  num_y,
  input  logic [COORD_W-1:0]  den_x,
  input  logic [COORD_W-1:0]  den_y,
  output logic [COORD_W-1:0]  rem_x,
  output logic [COORD_W-1:0]  rem_y
);

  // A zero divisor subtracts nothing, so the remainder comes out as the
  // dividend itself.
  function automatic logic [COORD_W-1:0] rem_step(input logic [COORD_W-1:0] r,
                                                  input logic b,
                                                  input logic [COORD_W-1:0] d);
    logic [COORD_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      return COORD_W'(t - {1'b0, d});
    end
    return t[COORD_W-1:0];
  endfunction

  logic [COORD_W-1:0] num [2];
  logic [COORD_W-1:0] den [2];

  logic [COORD_W-1:0] r1_nxt [2];
  logic [COORD_W-1:0] r2_nxt [2];
  logic [COORD_W-1:0] r3_nxt [2];

  logic [COORD_W-1:0] r1_r   [2];
  logic [3:0]         num1_r [2];
  logic [COORD_W-1:0] den1_r [2];
  logic [COORD_W-1:0] r2_r   [2];
  logic [1:0]         num2_r [2];
  logic [COORD_W-1:0] den2_r [2];
  logic [COORD_W-1:0] r3_r   [2];

  assign num[0] = num_x;
  assign num[1] = num_y;
  assign den[0] = den_x;
  assign den[1] = den_y;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r1_nxt[l] = rem_step(rem_step('0, num[l][5], den[l]), num[l][4], den[l]);
      r2_nxt[l] = rem_step(rem_step(r1_r[l], num1_r[l][3], den1_r[l]),
                           num1_r[l][2], den1_r[l]);
      r3_nxt[l] = rem_step(rem_step(r2_r[l], num2_r[l][1], den2_r[l]),
                           num2_r[l][0], den2_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (en.b) begin
        r1_r[l]   <= r1_nxt[l];
        num1_r[l] <= num[l][3:0];
        den1_r[l] <= den[l];
      end
      if (en.c) begin
        r2_r[l]   <= r2_nxt[l];
        num2_r[l] <= num1_r[l][1:0];
        den2_r[l] <= den1_r[l];
      end
      if (en.d) begin
        r3_r[l] <= r3_nxt[l];
      end
    end
  end

  assign rem_x = r3_r[0];
  assign rem_y = r3_r[1];

endmodule

// ===== src/afsg_addr_pipe.sv =====
// ----------------------------------------------------------------------------
// AFSG address pipeline
// Five register stages that turn one face cell into its row, neighbour base
// column and partner steps.
// ----------------------------------------------------------------------------
module afsg_addr_pipe import afsg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  afsg_size_t          size,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SIDE_W-1:0]   side,
  input  logic [KIND_W-1:0]   kind,
  input  logic [PIDX_W-1:0]   patch_index,
  input  logic [PIDX_W-1:0]   nbr_index_a,
  input  logic [PIDX_W-1:0]   nbr_index_b,
  input  logic [PIDX_W-1:0]   nbr_index_c,
  input  logic [PIDX_W-1:0]   nbr_index_d,
  input  logic [1:0]          coarse_quadrant,
  input  logic [COORD_W-1:0]  face_x,
  input  logic [COORD_W-1:0]  face_y,
  output logic                item_valid,
  input  logic                item_ready,
  output afsg_item_t          item
);

  logic en_a, en_b, en_c, en_d, en_e;
  afsg_pipe_en_t rem_en;

  // ---------------- stage A: captured input ----------------
  logic               a_v_r, a_v_nxt;
  logic [SIDE_W-1:0]  a_side_r;
  logic [KIND_W-1:0]  a_kind_r;
  logic [PIDX_W-1:0]  a_pidx_r;
  logic [PIDX_W-1:0]  a_nb_r [4];
  logic [1:0]         a_quad_r;
  logic [COORD_W-1:0] a_xi_r, a_yi_r;

  // ---------------- stage B ----------------
  logic               b_v_r;
  logic [KIND_W-1:0]  b_kind_r;
  logic [1:0]         b_axis_r;
  logic               b_odd_r;
  logic [PIDX_W-1:0]  b_pidx_r;
  logic [PIDX_W-1:0]  b_nb_r, b_nb_nxt;
  logic [COORD_W-1:0] b_xi_r, b_yi_r;
  logic [SIZE_W-1:0]  b_cx_r, b_cx_nxt, b_cy_r, b_cy_nxt;
  logic [AREA_W-1:0]  b_n01_r, b_n01_nxt;
  logic signed [15:0] b_m1_r, b_m1_nxt;
  logic               b_negx_r, b_negy_r;

  // ---------------- stage C ----------------
  logic               c_v_r;
  logic [KIND_W-1:0]  c_kind_r;
  logic               c_odd_r;
  logic [PIDX_W-1:0]  c_pidx_r, c_nb_r;
  logic [COORD_W-1:0] c_xi_r, c_yi_r;
  logic [SIZE_W-1:0]  c_cx_r, c_cy_r;
  logic [CELL_W-1:0]  c_cell_r, c_cell_nxt;
  logic [SIZE_W-1:0]  c_sx_r, c_sx_nxt;
  logic [AREA_W-1:0]  c_sy_r, c_sy_nxt;
  logic [IDX_W-1:0]   c_off_r, c_off_nxt;
  logic               c_negx_r, c_negy_r;

  // ---------------- stage D ----------------
  logic               d_v_r;
  logic [KIND_W-1:0]  d_kind_r;
  logic               d_odd_r;
  logic [IDX_W-1:0]   d_pc_r, d_nc_r, d_off_r;
  logic [21:0]        d_t2_r, d_t2_nxt;
  logic [SIZE_W-1:0]  d_sx_r;
  logic [AREA_W-1:0]  d_sy_r;
  logic [COORD_W-1:0] d_xi_r, d_yi_r;
  logic [SIZE_W-1:0]  d_cx_r, d_cy_r;
  logic [DELTA_W-1:0] d_dsx_r, d_dsx_nxt, d_dsy_r, d_dsy_nxt, d_dxy_r, d_dxy_nxt;

  // ---------------- stage E ----------------
  logic               e_v_r;
  logic [KIND_W-1:0]  e_kind_r;
  logic [IDX_W-1:0]   e_t1_r, e_t1_nxt, e_u1_r, e_u1_nxt;
  logic [21:0]        e_t2_r, e_u2_r, e_u2_nxt;
  logic [DELTA_W-1:0] e_dsx_r, e_dsy_r, e_dxy_r;

  // Combinational helpers
  logic [1:0]          a_axis;
  logic [SIZE_W-1:0]   nx, ny;
  logic [COORD_W-1:0]  hx, hy;
  logic [1:0]          quad_sel;
  logic [SIZE_W:0]     cx_sum, cy_sum;
  logic signed [7:0]   dec0, dec1, dec2;
  logic signed [22:0]  m2;
  logic [PIDX_W+CELL_W-1:0] pc_full, nc_full;
  logic [12:0]         sxxi;
  logic [19:0]         syyi;
  logic signed [DELTA_W-1:0] sx_s, sy_s;
  logic [COORD_W-1:0]  rem_x, rem_y;
  logic [SIZE_W-1:0]   bx, by;
  logic [13:0]         sxbx;
  logic [20:0]         syby;
  logic [IDX_W-1:0]    start_off, nbr_off;

  // Stages advance independently so bubbles are squeezed out under stall.
  assign en_e     = !e_v_r || item_ready;
  assign en_d     = !d_v_r || en_e;
  assign en_c     = !c_v_r || en_d;
  assign en_b     = !b_v_r || en_c;
  assign en_a     = !a_v_r || en_b;
  assign in_ready = en_a;

  assign rem_en.b = en_b;
  assign rem_en.c = en_c;
  assign rem_en.d = en_d;

  // Items with an unused face or kind code yield nothing and are dropped here.
  assign a_v_nxt = in_valid && (side <= SIDE_TOP) && (kind <= KIND_FINE);

  // ---------------- A -> B ----------------
  assign a_axis = a_side_r[2:1];

  always_comb begin
    unique case (a_axis)
      AXIS_X: begin
        nx = size.y;
        ny = size.z;
      end
      AXIS_Y: begin
        nx = size.x;
        ny = size.z;
      end
      default: begin
        nx = size.x;
        ny = size.y;
      end
    endcase
  end

  assign hx       = nx[SIZE_W-1:1];
  assign hy       = ny[SIZE_W-1:1];
  assign quad_sel = {a_yi_r >= hy, a_xi_r >= hx};
  assign b_nb_nxt = (a_kind_r == KIND_FINE) ? a_nb_r[quad_sel] : a_nb_r[0];

  assign cx_sum   = {2'b00, a_xi_r} + {1'b0, nx};
  assign cy_sum   = {2'b00, a_yi_r} + {1'b0, ny};
  assign b_cx_nxt = a_quad_r[0] ? cx_sum[SIZE_W:1] : {2'b00, a_xi_r[COORD_W-1:1]};
  assign b_cy_nxt = a_quad_r[1] ? cy_sum[SIZE_W:1] : {2'b00, a_yi_r[COORD_W-1:1]};

  assign b_n01_nxt = size.x * size.y;
  assign dec1      = $signed({1'b0, size.y}) - 8'sd1;
  assign b_m1_nxt  = dec1 * $signed({1'b0, size.x});

  // ---------------- B -> C ----------------
  assign c_cell_nxt = b_n01_r * size.z;
  assign c_sx_nxt   = (b_axis_r == AXIS_X) ? size.x : SIZE_W'(1);
  assign c_sy_nxt   = (b_axis_r == AXIS_Z) ? {{SIZE_W{1'b0}}, size.x} : b_n01_r;
  assign dec0       = $signed({1'b0, size.x}) - 8'sd1;
  assign dec2       = $signed({1'b0, size.z}) - 8'sd1;
  assign m2         = dec2 * $signed({1'b0, b_n01_r});

  // Offset of the far face along the normal axis; wraps when a size is zero.
  always_comb begin
    unique case (b_axis_r)
      AXIS_X:  c_off_nxt = IDX_W'(dec0);
      AXIS_Y:  c_off_nxt = IDX_W'(b_m1_r);
      default: c_off_nxt = IDX_W'(m2);
    endcase
  end

  // ---------------- C -> D ----------------
  assign pc_full   = c_pidx_r * c_cell_r;
  assign nc_full   = c_nb_r * c_cell_r;
  assign sxxi      = c_sx_r * c_xi_r;
  assign syyi      = c_sy_r * c_yi_r;
  assign d_t2_nxt  = 22'(sxxi) + 22'(syyi);
  assign sx_s      = $signed({{(DELTA_W-SIZE_W){1'b0}}, c_sx_r});
  assign sy_s      = $signed({{(DELTA_W-AREA_W){1'b0}}, c_sy_r});
  assign d_dsx_nxt = c_negx_r ? -sx_s : sx_s;
  assign d_dsy_nxt = c_negy_r ? -sy_s : sy_s;
  assign d_dxy_nxt = d_dsx_nxt + d_dsy_nxt;

  // ---------------- D -> E ----------------
  assign start_off = d_odd_r ? d_off_r : '0;
  assign nbr_off   = d_odd_r ? '0 : d_off_r;
  assign e_t1_nxt  = d_pc_r + start_off;
  assign e_u1_nxt  = d_nc_r + nbr_off;

  always_comb begin
    unique case (d_kind_r)
      KIND_COARSE: begin
        bx = d_cx_r;
        by = d_cy_r;
      end
      KIND_FINE: begin
        bx = {rem_x, 1'b0};
        by = {rem_y, 1'b0};
      end
      default: begin
        bx = {1'b0, d_xi_r};
        by = {1'b0, d_yi_r};
      end
    endcase
  end

  assign sxbx     = d_sx_r * bx;
  assign syby     = d_sy_r * by;
  assign e_u2_nxt = 22'(sxbx) + 22'(syby);

  // ---------------- E -> item ----------------
  assign item_valid = e_v_r;
  assign item.kind  = e_kind_r;
  assign item.row   = e_t1_r + IDX_W'(e_t2_r);
  assign item.bcol  = e_u1_r + IDX_W'(e_u2_r);
  assign item.dsx   = e_dsx_r;
  assign item.dsy   = e_dsy_r;
  assign item.dxy   = e_dxy_r;

  afsg_rem_pipe u_rem (
    .clk   (clk),
    .en    (rem_en),
    .num_x (a_xi_r),
    .num_y (a_yi_r),
    .den_x (hx),
    .den_y (hy),
    .rem_x (rem_x),
    .rem_y (rem_y)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= a_v_nxt;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r;
      if (en_d) d_v_r <= c_v_r;
      if (en_e) e_v_r <= d_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_side_r <= side;
      a_kind_r <= kind;
      a_pidx_r <= patch_index;
      a_nb_r[0] <= nbr_index_a;
      a_nb_r[1] <= nbr_index_b;
      a_nb_r[2] <= nbr_index_c;
      a_nb_r[3] <= nbr_index_d;
      a_quad_r <= coarse_quadrant;
      a_xi_r   <= face_x;
      a_yi_r   <= face_y;
    end
    if (en_b) begin
      b_kind_r <= a_kind_r;
      b_axis_r <= a_axis;
      b_odd_r  <= a_side_r[0];
      b_pidx_r <= a_pidx_r;
      b_nb_r   <= b_nb_nxt;
      b_xi_r   <= a_xi_r;
      b_yi_r   <= a_yi_r;
      b_cx_r   <= b_cx_nxt;
      b_cy_r   <= b_cy_nxt;
      b_n01_r  <= b_n01_nxt;
      b_m1_r   <= b_m1_nxt;
      b_negx_r <= (a_kind_r == KIND_COARSE) && a_xi_r[0];
      b_negy_r <= (a_kind_r == KIND_COARSE) && a_yi_r[0];
    end
    if (en_c) begin
      c_kind_r <= b_kind_r;
      c_odd_r  <= b_odd_r;
      c_pidx_r <= b_pidx_r;
      c_nb_r   <= b_nb_r;
      c_xi_r   <= b_xi_r;
      c_yi_r   <= b_yi_r;
      c_cx_r   <= b_cx_r;
      c_cy_r   <= b_cy_r;
      c_cell_r <= c_cell_nxt;
      c_sx_r   <= c_sx_nxt;
      c_sy_r   <= c_sy_nxt;
      c_off_r  <= c_off_nxt;
      c_negx_r <= b_negx_r;
      c_negy_r <= b_negy_r;
    end
    if (en_d) begin
      d_kind_r <= c_kind_r;
      d_odd_r  <= c_odd_r;
      d_pc_r   <= pc_full[IDX_W-1:0];
      d_nc_r   <= nc_full[IDX_W-1:0];
      d_off_r  <= c_off_r;
      d_t2_r   <= d_t2_nxt;
      d_sx_r   <= c_sx_r;
      d_sy_r   <= c_sy_r;
      d_xi_r   <= c_xi_r;
      d_yi_r   <= c_yi_r;
      d_cx_r   <= c_cx_r;
      d_cy_r   <= c_cy_r;
      d_dsx_r  <= d_dsx_nxt;
      d_dsy_r  <= d_dsy_nxt;
      d_dxy_r  <= d_dxy_nxt;
    end
    if (en_e) begin
      e_kind_r <= d_kind_r;
      e_t1_r   <= e_t1_nxt;
      e_t2_r   <= d_t2_r;
      e_u1_r   <= e_u1_nxt;
      e_u2_r   <= e_u2_nxt;
      e_dsx_r  <= d_dsx_r;
      e_dsy_r  <= d_dsy_r;
      e_dxy_r  <= d_dxy_r;
    end
  end

endmodule

// ===== src/afsg_entry_seq.sv =====
// ----------------------------------------------------------------------------
// AFSG entry sequencer
// Holds one face cell and issues its one or five matrix entries through a
// registered output.
// ----------------------------------------------------------------------------
module afsg_entry_seq import afsg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  afsg_item_t                item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_row,
  output logic [IDX_W-1:0]          out_col,
  output logic signed [COEF_W-1:0]  out_coeff,
  output logic                      out_last
);

  localparam logic [1:0] OFS_NONE = 2'd0;
  localparam logic [1:0] OFS_X    = 2'd1;
  localparam logic [1:0] OFS_Y    = 2'd2;
  localparam logic [1:0] OFS_XY   = 2'd3;

  localparam logic [2:0] LAST_K = 3'd4;

  logic        h_v_r, h_v_nxt;
  afsg_item_t  h_item_r;
  logic [2:0]  h_k_r, h_k_nxt;

  logic                     o_v_r, o_v_nxt;
  logic [IDX_W-1:0]         o_row_r, o_col_r, col_nxt;
  logic signed [COEF_W-1:0] o_coef_r, coef_nxt;
  logic                     o_last_r, last_nxt;

  logic             emit, use_b;
  logic [1:0]       ofs_sel;
  logic [IDX_W-1:0] ofs_val;

  assign emit       = h_v_r && (!o_v_r || out_ready);
  assign item_ready = !h_v_r || (emit && last_nxt);

  // Entry k of the held cell: coefficient, base column and partner step.
  always_comb begin
    coef_nxt = COEF_DIRICHLET;
    use_b    = 1'b0;
    ofs_sel  = OFS_NONE;
    last_nxt = 1'b1;
    unique case (h_item_r.kind)
      KIND_DIRICHLET: coef_nxt = COEF_DIRICHLET;
      KIND_NEUMANN:   coef_nxt = COEF_NEUMANN;
      KIND_SAME: begin
        coef_nxt = COEF_SAME;
        use_b    = 1'b1;
      end
      KIND_COARSE: begin
        last_nxt = (h_k_r == LAST_K);
        unique case (h_k_r)
          3'd0: coef_nxt = COEF_CRS_SELF;
          3'd1: begin
            coef_nxt = COEF_CRS_PARTNER;
            ofs_sel  = OFS_X;
          end
          3'd2: begin
            coef_nxt = COEF_CRS_PARTNER;
            ofs_sel  = OFS_Y;
          end
          3'd3: begin
            coef_nxt = COEF_CRS_PARTNER;
            ofs_sel  = OFS_XY;
          end
          default: begin
            coef_nxt = COEF_CRS_CELL;
            use_b    = 1'b1;
          end
        endcase
      end
      KIND_FINE: begin
        last_nxt = (h_k_r == LAST_K);
        unique case (h_k_r)
          3'd0: coef_nxt = COEF_FINE_SELF;
          3'd1: begin
            coef_nxt = COEF_FINE_CELL;
            use_b    = 1'b1;
          end
          3'd2: begin
            coef_nxt = COEF_FINE_CELL;
            use_b    = 1'b1;
            ofs_sel  = OFS_X;
          end
          3'd3: begin
            coef_nxt = COEF_FINE_CELL;
            use_b    = 1'b1;
            ofs_sel  = OFS_Y;
          end
          default: begin
            coef_nxt = COEF_FINE_CELL;
            use_b    = 1'b1;
            ofs_sel  = OFS_XY;
          end
        endcase
      end
      default: coef_nxt = COEF_DIRICHLET;
    endcase
  end

  always_comb begin
    unique case (ofs_sel)
      OFS_NONE: ofs_val = '0;
      OFS_X:    ofs_val = {{(IDX_W-DELTA_W){h_item_r.dsx[DELTA_W-1]}}, h_item_r.dsx};
      OFS_Y:    ofs_val = {{(IDX_W-DELTA_W){h_item_r.dsy[DELTA_W-1]}}, h_item_r.dsy};
      default:  ofs_val = {{(IDX_W-DELTA_W){h_item_r.dxy[DELTA_W-1]}}, h_item_r.dxy};
    endcase
  end

  assign col_nxt = (use_b ? h_item_r.bcol : h_item_r.row) + ofs_val;

  always_comb begin
    h_v_nxt = h_v_r;
    h_k_nxt = h_k_r;
    if (item_ready) begin
      h_v_nxt = item_valid;
      h_k_nxt = '0;
    end else if (emit) begin
      h_k_nxt = h_k_r + 3'd1;
    end
  end

  // The output register frees itself on a transfer and reloads in the same cycle.
  assign o_v_nxt = emit || (o_v_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
      h_k_r <= '0;
      o_v_r <= 1'b0;
    end else begin
      h_v_r <= h_v_nxt;
      h_k_r <= h_k_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      h_item_r <= item;
    end
    if (emit) begin
      o_row_r  <= h_item_r.row;
      o_col_r  <= col_nxt;
      o_coef_r <= coef_nxt;
      o_last_r <= last_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_row   = o_row_r;
  assign out_col   = o_col_r;
  assign out_coeff = o_coef_r;
  assign out_last  = o_last_r;

endmodule

// ===== src/amr_face_stencil_entry_gen.sv =====
// ----------------------------------------------------------------------------
// AMR face stencil entry generator
// Matrix entries of the ghost cell beyond one face cell of a 3-D patch.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one face cell per transfer: face and neighbour
//   kind in in_tuser, indexes, coarse quadrant and face coordinates in
//   in_tdata. The output stream carries one matrix entry per transfer, with
//   out_tlast marking the final entry of a cell. Dirichlet, Neumann and
//   same-level cells give one entry; coarse and fine cells give five.
//   Cells with an unused face or kind code are taken and give no entries.
//   The first entry of a cell reaches out_tvalid through the capture
//   register, the four address stages behind it, and the sequencer's
//   holding and output registers. While out_tready is high the sequencer
//   issues one entry per cycle, so the block takes one cell per cycle for
//   single-entry kinds and one coarse or fine cell per five entries. The
//   size registers are to be written through the cfg port while no cell
//   is in flight; the block does not enforce it. Reset sets each to 16 and
//   empties every stage. With out_tready low the entry stays put, the stages
//   fill behind it until in_tready drops, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module amr_face_stencil_entry_gen import afsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: patch_index[15:0], nbr_index_a[31:16], nbr_index_b[47:32],
  //        nbr_index_c[63:48], nbr_index_d[79:64], coarse_quadrant[81:80],
  //        face_x[87:82], face_y[93:88], zero padding[95:94]
  input  logic [95:0]           in_tdata,
  // tuser: side[2:0], nbr_kind[5:3]
  input  logic [5:0]            in_tuser,
  // Output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: row_index[33:0], col_index[67:34], coeff_sixths[71:68]
  output logic [71:0]           out_tdata,
  output logic                  out_tlast,
  // Configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_wdata
);

  afsg_size_t size_r, size_nxt;

  logic       item_valid, item_ready;
  afsg_item_t item;

  logic [IDX_W-1:0]         out_row, out_col;
  logic signed [COEF_W-1:0] out_coeff;

  // Sizes are kept even: the low bit of every write is dropped.
  always_comb begin
    size_nxt = size_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_nxt.x = {cfg_wdata[SIZE_W-1:1], 1'b0};
        CFG_SIZE_Y: size_nxt.y = {cfg_wdata[SIZE_W-1:1], 1'b0};
        CFG_SIZE_Z: size_nxt.z = {cfg_wdata[SIZE_W-1:1], 1'b0};
        default:    size_nxt   = size_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r.x <= SIZE_RESET;
      size_r.y <= SIZE_RESET;
      size_r.z <= SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  afsg_addr_pipe u_addr (
    .clk             (clk),
    .rst_n           (rst_n),
    .size            (size_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .side            (in_tuser[2:0]),
    .kind            (in_tuser[5:3]),
    .patch_index     (in_tdata[15:0]),
    .nbr_index_a     (in_tdata[31:16]),
    .nbr_index_b     (in_tdata[47:32]),
    .nbr_index_c     (in_tdata[63:48]),
    .nbr_index_d     (in_tdata[79:64]),
    .coarse_quadrant (in_tdata[81:80]),
    .face_x          (in_tdata[87:82]),
    .face_y          (in_tdata[93:88]),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item)
  );

  afsg_entry_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_coeff  (out_coeff),
    .out_last   (out_tlast)
  );

  assign out_tdata = {out_coeff, out_col, out_row};

endmodule

// ===== src/afsg_checker.sv =====
// ----------------------------------------------------------------------------
// AFSG checker
// Assertions on the output stream of the face stencil entry generator.
// ----------------------------------------------------------------------------
module afsg_checker import afsg_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);

  logic [COEF_W-1:0] coef;

  assign coef = out_tdata[2*IDX_W +: COEF_W];

  // The output register is emptied by reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled entry holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled entry changed");

  // The final entry of a cell carries a closing coefficient.
  a_last_coef: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && out_tlast |-> (coef == COEF_DIRICHLET || coef == COEF_NEUMANN ||
                                   coef == COEF_CRS_CELL || coef == COEF_FINE_CELL))
    else $error("bad coefficient on final entry");

  // Entries before the last belong to coarse or fine cells.
  a_mid_coef: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tlast |-> (coef == COEF_CRS_SELF || coef == COEF_CRS_PARTNER ||
                                    coef == COEF_FINE_SELF || coef == COEF_FINE_CELL))
    else $error("bad coefficient on inner entry");

endmodule

bind amr_face_stencil_entry_gen afsg_checker u_afsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Face stencil entry generator testbench
// Streams face cells into the block under several size settings and checks
// every matrix entry that comes out against an in-bench prediction of the
// row, column, coefficient and last-entry flag, with random idling on both
// streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import afsg_pkg::*;

  localparam logic [SIDE_W-1:0] SIDE_WEST      = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_EAST      = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_SOUTH     = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_NORTH     = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM    = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_UNUSED_LO = 3'd6;
  localparam logic [SIDE_W-1:0] SIDE_UNUSED_HI = 3'd7;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  localparam int DRAIN_CYCLES   = 20;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [SIDE_W-1:0]          side;
    logic [KIND_W-1:0]          kind;
    logic [PIDX_W-1:0]          patch;
    logic [3:0][PIDX_W-1:0]     nbr;   // quadrant 0 in the low bits
    logic [1:0]                 quad;
    logic [COORD_W-1:0]         fx;
    logic [COORD_W-1:0]         fy;
  } cell_t;

  typedef struct packed {
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic signed [COEF_W-1:0]   coeff;
    logic                       last;
  } entry_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [95:0]           in_tdata   = '0;
  logic [5:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [71:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_SIZE_X;
  logic [SIZE_W-1:0]     cfg_wdata  = '0;

  // Shadow of the size registers as the block should hold them.
  logic [SIZE_W-1:0]     sz_x = SIZE_RESET;
  logic [SIZE_W-1:0]     sz_y = SIZE_RESET;
  logic [SIZE_W-1:0]     sz_z = SIZE_RESET;

  cell_t                 pending_cells[$];
  entry_t                expected_entries[$];
  cell_t                 cur_cell;
  int                    src_idle_max  = 0;
  int                    sink_idle_max = 0;
  int                    src_gap       = 0;
  int                    sink_stall    = 0;
  int                    hold_reqs     = 0;
  int                    hold_seen     = 0;
  int                    quiet_cycles  = 0;
  int                    n_cells       = 0;
  int                    n_entries     = 0;
  int                    n_settings    = 0;
  int                    n_errors      = 0;

  amr_face_stencil_entry_gen u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void add_entry(logic [63:0] row, logic [63:0] col,
                                    logic signed [COEF_W-1:0] coeff, logic last);
    entry_t e;
    e.row   = row[IDX_W-1:0];
    e.col   = col[IDX_W-1:0];
    e.coeff = coeff;
    e.last  = last;
    expected_entries.push_back(e);
  endfunction

  // Works out the entries of one face cell. Everything is done modulo 2^64
  // and cut to the index width at the end, which matches wrapping at 2^34.
  function automatic void predict_entries(cell_t c);
    logic [63:0] n0, n1, n2, vol, start, noff, sx, sy, nx, ny, row, base;
    logic [63:0] xi, yi, pxi, pyi, cx, cy, hx, hy, fx, fy;
    logic [1:0]  q;
    n0  = 64'(sz_x);
    n1  = 64'(sz_y);
    n2  = 64'(sz_z);
    vol = n0 * n1 * n2;
    xi  = 64'(c.fx);
    yi  = 64'(c.fy);
    if (c.side > SIDE_TOP || c.kind > KIND_FINE) return;
    start = 64'(c.patch) * vol;
    unique case (c.side)
      SIDE_WEST: begin
        noff = n0 - 1; sx = n0; sy = n0 * n1; nx = n1; ny = n2;
      end
      SIDE_EAST: begin
        start += n0 - 1; noff = 0; sx = n0; sy = n0 * n1; nx = n1; ny = n2;
      end
      SIDE_SOUTH: begin
        noff = (n1 - 1) * n0; sx = 1; sy = n0 * n1; nx = n0; ny = n2;
      end
      SIDE_NORTH: begin
        start += (n1 - 1) * n0; noff = 0; sx = 1; sy = n0 * n1; nx = n0; ny = n2;
      end
      SIDE_BOTTOM: begin
        noff = (n2 - 1) * n1 * n0; sx = 1; sy = n0; nx = n0; ny = n1;
      end
      default: begin
        start += (n2 - 1) * n1 * n0; noff = 0; sx = 1; sy = n0; nx = n0; ny = n1;
      end
    endcase
    row = start + sx * xi + sy * yi;
    unique case (c.kind)
      KIND_DIRICHLET: add_entry(row, row, COEF_DIRICHLET, 1'b1);
      KIND_NEUMANN:   add_entry(row, row, COEF_NEUMANN, 1'b1);
      KIND_SAME: begin
        base = 64'(c.nbr[0]) * vol + noff;
        add_entry(row, base + sx * xi + sy * yi, COEF_SAME, 1'b1);
      end
      KIND_COARSE: begin
        // Partners pair even with odd cells; the coarse cell sits in the
        // quarter of the coarse face given by the quadrant bits.
        pxi  = xi[0] ? xi - 1 : xi + 1;
        pyi  = yi[0] ? yi - 1 : yi + 1;
        cx   = c.quad[0] ? (xi + nx) >> 1 : xi >> 1;
        cy   = c.quad[1] ? (yi + ny) >> 1 : yi >> 1;
        base = 64'(c.nbr[0]) * vol + noff;
        add_entry(row, start + sx * xi  + sy * yi,  COEF_CRS_SELF, 1'b0);
        add_entry(row, start + sx * pxi + sy * yi,  COEF_CRS_PARTNER, 1'b0);
        add_entry(row, start + sx * xi  + sy * pyi, COEF_CRS_PARTNER, 1'b0);
        add_entry(row, start + sx * pxi + sy * pyi, COEF_CRS_PARTNER, 1'b0);
        add_entry(row, base + sx * cx + sy * cy, COEF_CRS_CELL, 1'b1);
      end
      KIND_FINE: begin
        // A half size of zero leaves the coordinate as it is.
        hx   = nx >> 1;
        hy   = ny >> 1;
        q    = {yi >= hy, xi >= hx};
        fx   = ((hx == 0) ? xi : xi % hx) << 1;
        fy   = ((hy == 0) ? yi : yi % hy) << 1;
        base = 64'(c.nbr[q]) * vol + noff;
        add_entry(row, row, COEF_FINE_SELF, 1'b0);
        add_entry(row, base + sx * fx       + sy * fy,       COEF_FINE_CELL, 1'b0);
        add_entry(row, base + sx * (fx + 1) + sy * fy,       COEF_FINE_CELL, 1'b0);
        add_entry(row, base + sx * fx       + sy * (fy + 1), COEF_FINE_CELL, 1'b0);
        add_entry(row, base + sx * (fx + 1) + sy * (fy + 1), COEF_FINE_CELL, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic cell_t mk_cell(logic [SIDE_W-1:0] side, logic [KIND_W-1:0] kind,
                                    logic [PIDX_W-1:0] patch, logic [PIDX_W-1:0] nbr,
                                    logic [1:0] quad, logic [COORD_W-1:0] fx,
                                    logic [COORD_W-1:0] fy);
    cell_t c;
    c.side  = side;
    c.kind  = kind;
    c.patch = patch;
    c.nbr   = {~nbr, nbr ^ 16'h5A5A, ~nbr ^ 16'h0F0F, nbr};
    c.quad  = quad;
    c.fx    = fx;
    c.fy    = fy;
    return c;
  endfunction

  // Mostly inside the face, now and then anywhere in the coordinate range.
  function automatic logic [COORD_W-1:0] rand_coord(logic [SIZE_W-1:0] n);
    if (n == 0 || $urandom_range(0, 3) == 0) return COORD_W'($urandom_range(0, 63));
    return COORD_W'($urandom_range(0, (n > 64) ? 63 : int'(n) - 1));
  endfunction

  function automatic cell_t rand_cell();
    cell_t             c;
    int                r;
    logic [SIZE_W-1:0] span_a, span_b;
    c.side = SIDE_W'($urandom_range(int'(SIDE_WEST), int'(SIDE_TOP)));
    r = $urandom_range(0, 9);
    c.kind = (r == 0) ? KIND_DIRICHLET : (r == 1) ? KIND_NEUMANN :
             (r == 2) ? KIND_SAME : (r < 6) ? KIND_COARSE : KIND_FINE;
    c.patch = PIDX_W'($urandom);
    c.nbr   = {$urandom, $urandom};
    c.quad  = 2'($urandom);
    if (c.side <= SIDE_EAST) begin
      span_a = sz_y; span_b = sz_z;
    end else if (c.side <= SIDE_NORTH) begin
      span_a = sz_x; span_b = sz_z;
    end else begin
      span_a = sz_x; span_b = sz_y;
    end
    c.fx = rand_coord(span_a);
    c.fy = rand_coord(span_b);
    // A little noise: unused face and kind codes.
    r = $urandom_range(0, 19);
    if (r == 0) begin
      c.side = SIDE_W'($urandom_range(int'(SIDE_UNUSED_LO), int'(SIDE_UNUSED_HI)));
    end else if (r == 1) begin
      c.kind = KIND_W'($urandom_range(int'(KIND_UNUSED_LO), int'(KIND_UNUSED_HI)));
    end
    return c;
  endfunction

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // Waits until every queued cell is taken and every entry has come back,
  // then gives the pipeline time to swallow cells that produce nothing.
  task automatic wait_drained();
    while (pending_cells.size() != 0 || in_tvalid || expected_entries.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sz_x <= SIZE_RESET;
      sz_y <= SIZE_RESET;
      sz_z <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SIZE_X: sz_x <= {cfg_wdata[SIZE_W-1:1], 1'b0};
        CFG_SIZE_Y: sz_y <= {cfg_wdata[SIZE_W-1:1], 1'b0};
        CFG_SIZE_Z: sz_z <= {cfg_wdata[SIZE_W-1:1], 1'b0};
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_entries(cur_cell);
        n_cells++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap != 0) begin
          in_tvalid <= 1'b0;
          src_gap   <= src_gap - 1;
        end else if (pending_cells.size() != 0) begin
          cur_cell  = pending_cells.pop_front();
          in_tdata  <= {2'b00, cur_cell.fy, cur_cell.fx, cur_cell.quad,
                        cur_cell.nbr, cur_cell.patch};
          in_tuser  <= {cur_cell.kind, cur_cell.side};
          in_tvalid <= 1'b1;
          src_gap   <= $urandom_range(0, src_idle_max);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    int     stall;
    entry_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_stall <= 0;
    end else begin
      stall = sink_stall;
      if (out_tvalid && out_tready) begin
        n_entries++;
        if (expected_entries.size() == 0) begin
          $error("unexpected entry: row %h col %h coeff %0d last %b",
                 out_tdata[33:0], out_tdata[67:34], $signed(out_tdata[71:68]), out_tlast);
          n_errors++;
        end else begin
          want = expected_entries.pop_front();
          if (out_tdata[33:0] !== want.row) begin
            $error("row_index: expected %h, got %h", want.row, out_tdata[33:0]);
            n_errors++;
          end
          if (out_tdata[67:34] !== want.col) begin
            $error("col_index: expected %h, got %h", want.col, out_tdata[67:34]);
            n_errors++;
          end
          if (out_tdata[71:68] !== want.coeff) begin
            $error("coeff_sixths: expected %0d, got %0d", want.coeff,
                   $signed(out_tdata[71:68]));
            n_errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last_entry: expected %b, got %b", want.last, out_tlast);
            n_errors++;
          end
        end
        stall = $urandom_range(0, sink_idle_max);
      end
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        stall = LONG_HOLD;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        sink_stall <= stall - 1;
      end else begin
        out_tready <= 1'b1;
        sink_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                s;
    int                p;
    int                count;
    logic [SIZE_W-1:0] wx, wy, wz;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cells at the reset sizes: every face with coarse and fine
    // neighbours, all quadrants, extreme indexes and unused codes.
    for (s = int'(SIDE_WEST); s <= int'(SIDE_TOP); s++) begin
      pending_cells.push_back(mk_cell(SIDE_W'(s), KIND_COARSE, 16'(s * 1000),
                                      16'(65535 - s), 2'(s), 6'(s), 6'(s + 1)));
      pending_cells.push_back(mk_cell(SIDE_W'(s), KIND_FINE, 16'(s * 77), 16'(s * 4099),
                                      2'(s), s[0] ? 6'(8 + s) : 6'(s), s[1] ? 6'd9 : 6'd2));
    end
    pending_cells.push_back(mk_cell(SIDE_TOP, KIND_FINE, 16'hFFFF, 16'hFFFF, 2'd3,
                                    6'd63, 6'd63));
    pending_cells.push_back(mk_cell(SIDE_NORTH, KIND_COARSE, 16'hFFFF, 16'hFFFF, 2'd3,
                                    6'd63, 6'd63));
    pending_cells.push_back(mk_cell(SIDE_WEST, KIND_DIRICHLET, 16'hFFFF, 16'h0000, 2'd0,
                                    6'd63, 6'd63));
    pending_cells.push_back(mk_cell(SIDE_EAST, KIND_NEUMANN, 16'h0000, 16'hFFFF, 2'd1,
                                    6'd0, 6'd0));
    pending_cells.push_back(mk_cell(SIDE_BOTTOM, KIND_SAME, 16'hFFFF, 16'hFFFF, 2'd2,
                                    6'd63, 6'd0));
    pending_cells.push_back(mk_cell(SIDE_UNUSED_LO, KIND_COARSE, 16'd1, 16'd2, 2'd0,
                                    6'd1, 6'd1));
    pending_cells.push_back(mk_cell(SIDE_UNUSED_HI, KIND_DIRICHLET, 16'd3, 16'd4, 2'd0,
                                    6'd2, 6'd2));
    pending_cells.push_back(mk_cell(SIDE_WEST, KIND_UNUSED_LO, 16'd5, 16'd6, 2'd0,
                                    6'd3, 6'd3));
    pending_cells.push_back(mk_cell(SIDE_TOP, KIND_UNUSED_HI, 16'd7, 16'd8, 2'd0,
                                    6'd4, 6'd4));
    n_settings = 1;

    // Random phases. Each starts only when the block has drained, so the
    // sender also pauses there until every entry has come back.
    for (p = 1; p <= 6; p++) begin
      wait_drained();
      unique case (p)
        1: begin
          wx = 7'd3; wy = 7'd2; wz = 7'd5;
          src_idle_max = 15; sink_idle_max = 15; count = 25;
        end
        2: begin
          wx = 7'd127; wy = 7'd127; wz = 7'd126;
          src_idle_max = 0; sink_idle_max = 0; count = 35;
        end
        3: begin
          // Zero sizes: the arithmetic wraps and fine half sizes are zero.
          wx = 7'd1; wy = 7'd64; wz = 7'd0;
          src_idle_max = 15; sink_idle_max = 0; count = 30;
        end
        4: begin
          wx = SIZE_W'($urandom_range(2, 127)); wy = SIZE_W'($urandom_range(2, 127));
          wz = SIZE_W'($urandom_range(2, 127));
          src_idle_max = 0; sink_idle_max = 0; count = 30;
        end
        5: begin
          wx = 7'd16; wy = 7'd6; wz = 7'd127;
          src_idle_max = 0; sink_idle_max = 15; count = 35;
        end
        default: begin
          wx = SIZE_W'($urandom_range(0, 127)); wy = SIZE_W'($urandom_range(0, 127));
          wz = SIZE_W'($urandom_range(0, 127));
          src_idle_max = 15; sink_idle_max = 15; count = 35;
        end
      endcase
      write_size(CFG_SIZE_X, wx);
      write_size(CFG_SIZE_Y, wy);
      write_size(CFG_SIZE_Z, wz);
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      n_settings++;
      @(negedge clk);
      repeat (count) pending_cells.push_back(rand_cell());
      if (p == 4) begin
        // Hold the output off while cells keep arriving, so the stages fill
        // and the input stalls.
        @(posedge clk);
        hold_reqs <= hold_reqs + 1;
      end
    end
    wait_drained();

    if (expected_entries.size() != 0) begin
      $error("%0d expected entries never arrived", expected_entries.size());
      n_errors++;
    end
    $display("Run covered %0d face cells and %0d matrix entries over %0d size settings,",
             n_cells, n_entries, n_settings);
    $display("including zero and maximum sizes, random idling and one long hold-off.");
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
